[hw/rtl/ctsr_pkg.sv]
// Package: constants, codes and types shared by the cache tag store blocks.
package ctsr_pkg;

  localparam int unsigned MaxLines = 1024;
  localparam int unsigned SetWays  = 4;
  localparam int unsigned AddrBits = 32;
  localparam int unsigned TagBits  = 30;
  localparam int unsigned CfgWidth = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgKbLog2    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockLog2 = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMapping   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPolicy    = 2'd3;

  localparam logic [1:0] MapDirect = 2'd0;
  localparam logic [1:0] MapSetAssoc = 2'd1;
  localparam logic [1:0] MapFull = 2'd2;

  localparam logic [1:0] PolFifo = 2'd0;
  localparam logic [1:0] PolLru = 2'd1;
  localparam logic [1:0] PolMru = 2'd2;

  localparam logic [1:0] ClsHit = 2'd0;
  localparam logic [1:0] ClsCompulsory = 2'd1;
  localparam logic [1:0] ClsConflict = 2'd2;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StSearch,
    StMvRd,
    StMvWr,
    StPut,
    StDone
  } state_e;

endpackage

[hw/rtl/ctsr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ctsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/cache_tag_store_replacement.sv]
// Top level: tag store, set walk and replacement of a configurable cache.
// One address per start request, taken while busy is low. Each line is one RAM entry
// holding a valid bit and the tag; after reset busy stays high while a clearing pass
// marks every line empty. An access walks its set in stored order with a read and a
// compare state per way examined, then, where the policy needs it, reorders the set
// with a read and a write state per entry moved, writes the accessed tag (skipped on
// a FIFO hit) and raises the result strobe. busy drops in the cycle after the strobe,
// so a new request can be taken from that cycle on. result_valid_o lasts one cycle
// and the receiver cannot stall it.
module cache_tag_store_replacement #(
  parameter int unsigned MAX_LINES = ctsr_pkg::MaxLines,
  parameter int unsigned SET_WAYS  = ctsr_pkg::SetWays,
  parameter int unsigned ADDR_BITS = ctsr_pkg::AddrBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ctsr_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   address_i,
  output logic                          result_valid_o,
  output logic [1:0]                    access_class_o,
  output logic                          victim_valid_o,
  output logic [29:0]                   victim_tag_o
);

  localparam int unsigned IdxW = $clog2(MAX_LINES);
  localparam int unsigned LlMax = $clog2(MAX_LINES + 1) - 1;
  localparam int unsigned WayLog = $clog2(SET_WAYS);
  localparam int unsigned TagW = ctsr_pkg::TagBits;
  localparam int unsigned EntW = TagW + 1;
  localparam logic [IdxW:0] IOne = (IdxW+1)'(1);
  localparam logic [IdxW-1:0] AOne = IdxW'(1);
  localparam logic [IdxW-1:0] ClrLast = IdxW'(MAX_LINES - 1);

  logic [3:0] kb_q, ob_q;
  logic [1:0] map_q, pol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kb_q <= 4'd4;
      ob_q <= 4'd4;
      map_q <= ctsr_pkg::MapDirect;
      pol_q <= ctsr_pkg::PolFifo;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctsr_pkg::CfgKbLog2:    kb_q <= cfg_wdata_i;
        ctsr_pkg::CfgBlockLog2: ob_q <= cfg_wdata_i;
        ctsr_pkg::CfgMapping:   map_q <= cfg_wdata_i[1:0];
        ctsr_pkg::CfgPolicy:    pol_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Geometry.
  logic [3:0] kb_c, ob_c;
  logic [4:0] ll_raw, ll_c, sl_c;
  logic [IdxW:0] ways_c;
  always_comb begin
    kb_c = (kb_q > 4'd10) ? 4'd10 : kb_q;
    ob_c = (ob_q < 4'd2) ? 4'd2 : ((ob_q > 4'd10) ? 4'd10 : ob_q);
    ll_raw = 5'd10 + {1'b0, kb_c} - {1'b0, ob_c};
    ll_c = (ll_raw > 5'(LlMax)) ? 5'(LlMax) : ll_raw;
    sl_c = 5'd0;
    if (map_q == ctsr_pkg::MapFull) begin
      ways_c = (IdxW+1)'(1) << ll_c;
    end else if (map_q == ctsr_pkg::MapSetAssoc) begin
      if (ll_c < 5'(WayLog)) begin
        ways_c = (IdxW+1)'(1) << ll_c;
      end else begin
        ways_c = (IdxW+1)'(SET_WAYS);
        sl_c = ll_c - 5'(WayLog);
      end
    end else begin
      ways_c = (IdxW+1)'(1);
      sl_c = ll_c;
    end
  end

  logic [ADDR_BITS-1:0] addr_c;
  logic [TagW-1:0] tag_c;
  logic [IdxW-1:0] setidx_c, base_c;
  assign addr_c = ADDR_BITS'({32'd0, address_i});
  assign tag_c = TagW'(addr_c >> ({1'b0, ob_c} + sl_c));
  assign setidx_c = IdxW'((addr_c >> ob_c) & ((ADDR_BITS'(1) << sl_c) - ADDR_BITS'(1)));
  assign base_c = IdxW'(setidx_c * ways_c);

  ctsr_pkg::state_e state_q, state_d;
  logic [TagW-1:0] tag_q, tag_d, first_q, first_d, vtag_q, vtag_d;
  logic [IdxW-1:0] base_q, base_d, put_q, put_d, clr_q, clr_d;
  logic [IdxW:0] ways_q, ways_d, i_q, i_d;
  logic [1:0] cls_q, cls_d, pol_s_q, pol_s_d;
  logic vvalid_q, vvalid_d;

  logic ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0] ram_wdata, ram_rdata;

  ctsr_ram #(.Width(EntW), .Depth(MAX_LINES)) u_tags (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  logic [IdxW-1:0] cur_idx;
  logic ent_valid, lru_like, srch_end, need_move, mv_last;
  logic [TagW-1:0] ent_tag, first_tag;
  logic [1:0] srch_cls;
  assign cur_idx = base_q + i_q[IdxW-1:0];
  assign ent_valid = ram_rdata[TagW];
  assign ent_tag = ram_rdata[TagW-1:0];
  assign first_tag = (i_q == '0) ? ent_tag : first_q;
  assign lru_like = (pol_s_q != ctsr_pkg::PolFifo);
  assign srch_cls = (ent_valid && ent_tag == tag_q) ? ctsr_pkg::ClsHit :
                    (!ent_valid) ? ctsr_pkg::ClsCompulsory : ctsr_pkg::ClsConflict;
  assign srch_end = (srch_cls != ctsr_pkg::ClsConflict) || (i_q + IOne == ways_q);
  // LRU moves entries up to the found position, MRU too except on a conflict; FIFO shifts down on a conflict.
  assign need_move = (i_q != '0) &&
                     (lru_like ? !(pol_s_q == ctsr_pkg::PolMru &&
                                   srch_cls == ctsr_pkg::ClsConflict)
                               : (srch_cls == ctsr_pkg::ClsConflict));
  assign mv_last = lru_like ? (i_q == IOne) : (i_q == ways_q - IOne);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ctsr_pkg::StClear: begin
        if (clr_q == ClrLast) state_d = ctsr_pkg::StIdle;
      end
      ctsr_pkg::StIdle: begin
        if (start) state_d = ctsr_pkg::StRead;
      end
      ctsr_pkg::StRead: state_d = ctsr_pkg::StSearch;
      ctsr_pkg::StSearch: begin
        if (!srch_end) begin
          state_d = ctsr_pkg::StRead;
        end else if (!lru_like && srch_cls == ctsr_pkg::ClsHit) begin
          state_d = ctsr_pkg::StDone;
        end else if (need_move) begin
          state_d = ctsr_pkg::StMvRd;
        end else begin
          state_d = ctsr_pkg::StPut;
        end
      end
      ctsr_pkg::StMvRd: state_d = ctsr_pkg::StMvWr;
      ctsr_pkg::StMvWr: begin
        state_d = mv_last ? ctsr_pkg::StPut : ctsr_pkg::StMvRd;
      end
      ctsr_pkg::StPut: state_d = ctsr_pkg::StDone;
      default: state_d = ctsr_pkg::StIdle;
    endcase
  end

  // Datapath registers.
  always_comb begin
    tag_d = tag_q; first_d = first_q; vtag_d = vtag_q; vvalid_d = vvalid_q;
    cls_d = cls_q; pol_s_d = pol_s_q; base_d = base_q; ways_d = ways_q;
    i_d = i_q; put_d = put_q; clr_d = clr_q;
    case (state_q)
      ctsr_pkg::StClear: clr_d = clr_q + AOne;
      ctsr_pkg::StIdle: begin
        if (start) begin
          tag_d = tag_c;
          base_d = base_c;
          ways_d = ways_c;
          pol_s_d = (pol_q == ctsr_pkg::PolLru || pol_q == ctsr_pkg::PolMru) ? pol_q
                                                                             : ctsr_pkg::PolFifo;
          i_d = '0;
          cls_d = ctsr_pkg::ClsHit;
          vvalid_d = 1'b0;
          vtag_d = '0;
        end
      end
      ctsr_pkg::StSearch: begin
        if (i_q == '0) first_d = ent_tag;
        if (!srch_end) begin
          i_d = i_q + IOne;
        end else begin
          cls_d = srch_cls;
          if (lru_like) begin
            put_d = base_q;
            if (srch_cls == ctsr_pkg::ClsConflict) begin
              vvalid_d = 1'b1;
              vtag_d = (pol_s_q == ctsr_pkg::PolMru) ? first_tag : ent_tag;
            end
          end else begin
            put_d = cur_idx;
            if (srch_cls == ctsr_pkg::ClsConflict) begin
              vvalid_d = 1'b1;
              vtag_d = first_tag;
              i_d = IOne;
            end
          end
        end
      end
      ctsr_pkg::StMvWr: i_d = lru_like ? i_q - IOne : i_q + IOne;
      default: ;
    endcase
  end

  // RAM control.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = ram_rdata;
    ram_raddr = cur_idx;
    case (state_q)
      ctsr_pkg::StClear: begin
        ram_we = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ctsr_pkg::StMvRd: ram_raddr = lru_like ? cur_idx - AOne : cur_idx;
      ctsr_pkg::StMvWr: begin
        ram_we = 1'b1;
        ram_waddr = lru_like ? cur_idx : cur_idx - AOne;
      end
      ctsr_pkg::StPut: begin
        ram_we = 1'b1;
        ram_waddr = put_q;
        ram_wdata = {1'b1, tag_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctsr_pkg::StClear;
      tag_q <= '0; first_q <= '0; vtag_q <= '0; vvalid_q <= 1'b0;
      cls_q <= ctsr_pkg::ClsHit; pol_s_q <= ctsr_pkg::PolFifo;
      base_q <= '0; ways_q <= '0; i_q <= '0; put_q <= '0; clr_q <= '0;
    end else begin
      state_q <= state_d;
      tag_q <= tag_d; first_q <= first_d; vtag_q <= vtag_d; vvalid_q <= vvalid_d;
      cls_q <= cls_d; pol_s_q <= pol_s_d;
      base_q <= base_d; ways_q <= ways_d; i_q <= i_d; put_q <= put_d; clr_q <= clr_d;
    end
  end

  assign busy = (state_q != ctsr_pkg::StIdle);
  assign result_valid_o = (state_q == ctsr_pkg::StDone);
  assign access_class_o = cls_q;
  assign victim_valid_o = vvalid_q;
  assign victim_tag_o = vtag_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("strobe longer than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && access_class_o != ctsr_pkg::ClsConflict |-> !victim_valid_o)
    else $error("victim reported without conflict");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request not taken");

endmodule

[sim/tb_cache_tag_store_replacement.sv]
// Testbench: random and directed address requests checked against a tag store predictor.
module tb_cache_tag_store_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 40000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ctsr_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ctsr_pkg::CfgWidth-1:0] cfg_wdata_i;
  logic                          start;
  logic                          busy;
  logic [31:0]                   address_i;
  logic                          result_valid_o;
  logic [1:0]                    access_class_o;
  logic                          victim_valid_o;
  logic [29:0]                   victim_tag_o;

  typedef struct packed {
    logic [1:0]  cls;
    logic        vvalid;
    logic [29:0] vtag;
  } access_result_t;

  logic [31:0]    pending_addr[$];
  access_result_t expected_res[$];
  logic [29:0]    tag_mem[ctsr_pkg::MaxLines];
  logic           valid_mem[ctsr_pkg::MaxLines];
  int unsigned    cur_kb, cur_blk, cur_map, cur_pol;
  int unsigned    err_cnt;
  int unsigned    quiet_cnt;
  bit             no_idle;
  logic [15:0]    hi_pool[6];
  logic [15:0]    lo_pool[6];

  cache_tag_store_replacement dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic access_result_t predict_access(input logic [31:0] a);
    access_result_t r;
    int unsigned kb, ob, ll, lines, sl, ways, base, pos, i;
    logic [63:0] a64;
    logic [29:0] tag;
    kb = (cur_kb > 10) ? 10 : cur_kb;
    ob = (cur_blk < 2) ? 2 : ((cur_blk > 10) ? 10 : cur_blk);
    ll = 10 + kb - ob;
    while (ll > 0 && (1 << ll) > ctsr_pkg::MaxLines) ll--;
    lines = 1 << ll;
    sl = 0;
    if (cur_map == ctsr_pkg::MapFull) begin
      ways = lines;
    end else if (cur_map == ctsr_pkg::MapSetAssoc) begin
      if (lines < ctsr_pkg::SetWays) begin
        ways = lines;
      end else begin
        ways = ctsr_pkg::SetWays;
        sl = ll;
        while (sl > 0 && ((1 << sl) * ctsr_pkg::SetWays) > lines) sl--;
      end
    end else begin
      ways = 1;
      sl = ll;
    end
    a64 = {32'd0, a};
    tag = 30'(a64 >> (sl + ob));
    base = 32'(((a64 >> ob) & ((64'd1 << sl) - 64'd1)) * ways);
    r = '0;
    r.cls = ctsr_pkg::ClsConflict;
    pos = 0;
    for (i = 0; i < ways; i++) begin
      if (valid_mem[base+i] && tag_mem[base+i] == tag) begin
        r.cls = ctsr_pkg::ClsHit; pos = i; break;
      end
      if (!valid_mem[base+i]) begin
        r.cls = ctsr_pkg::ClsCompulsory; pos = i; break;
      end
    end
    if (cur_pol == ctsr_pkg::PolLru || cur_pol == ctsr_pkg::PolMru) begin
      if (r.cls != ctsr_pkg::ClsConflict) begin
        for (i = pos; i >= 1; i--) begin
          tag_mem[base+i] = tag_mem[base+i-1];
          valid_mem[base+i] = valid_mem[base+i-1];
        end
      end else if (cur_pol == ctsr_pkg::PolLru) begin
        r.vvalid = 1'b1;
        r.vtag = tag_mem[base+ways-1];
        for (i = ways - 1; i >= 1; i--) begin
          tag_mem[base+i] = tag_mem[base+i-1];
          valid_mem[base+i] = valid_mem[base+i-1];
        end
      end else begin
        r.vvalid = 1'b1;
        r.vtag = tag_mem[base];
      end
      tag_mem[base] = tag;
      valid_mem[base] = 1'b1;
    end else if (r.cls == ctsr_pkg::ClsCompulsory) begin
      tag_mem[base+pos] = tag;
      valid_mem[base+pos] = 1'b1;
    end else if (r.cls == ctsr_pkg::ClsConflict) begin
      r.vvalid = 1'b1;
      r.vtag = tag_mem[base];
      for (i = 1; i < ways; i++) begin
        tag_mem[base+i-1] = tag_mem[base+i];
        valid_mem[base+i-1] = valid_mem[base+i];
      end
      tag_mem[base+ways-1] = tag;
      valid_mem[base+ways-1] = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      address_i <= '0;
    end else begin
      if (start && !busy) expected_res.push_back(predict_access(address_i));
      if (!(start && busy)) begin
        if (pending_addr.size() > 0 && (no_idle || $urandom_range(0, 99) >= 20)) begin
          start <= 1'b1;
          address_i <= pending_addr.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    access_result_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result");
      end else begin
        e = expected_res.pop_front();
        if (access_class_o !== e.cls)
          report_mismatch($sformatf("class %0d exp %0d", access_class_o, e.cls));
        if (victim_valid_o !== e.vvalid)
          report_mismatch($sformatf("victim_valid %0b exp %0b", victim_valid_o, e.vvalid));
        if (victim_tag_o !== e.vtag)
          report_mismatch($sformatf("victim_tag %h exp %h", victim_tag_o, e.vtag));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= WatchLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    wait (pending_addr.size() == 0 && !start && expected_res.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ctsr_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[ctsr_pkg::CfgWidth-1:0];
    case (idx)
      ctsr_pkg::CfgKbLog2:    cur_kb = val & 4'hF;
      ctsr_pkg::CfgBlockLog2: cur_blk = val & 4'hF;
      ctsr_pkg::CfgMapping:   cur_map = val & 2'h3;
      ctsr_pkg::CfgPolicy:    cur_pol = val & 2'h3;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_addr();
    if ($urandom_range(0, 99) < 25) return $urandom();
    return {hi_pool[$urandom_range(0, 5)], lo_pool[$urandom_range(0, 5)]} ^
           32'($urandom_range(0, 15));
  endfunction

  // phase table: kb, block, mapping, policy, item count
  int unsigned ph_kb[15]  = '{4, 0, 10, 2, 0, 1, 15, 3, 0, 4, 10, 2, 0, 5, 4};
  int unsigned ph_blk[15] = '{4, 10, 2, 6, 6, 9, 0, 15, 7, 4, 2, 8, 10, 5, 4};
  int unsigned ph_map[15] = '{0, 1, 1, 1, 2, 1, 0, 3, 2, 2, 0, 1, 2, 1, 2};
  int unsigned ph_pol[15] = '{0, 0, 1, 2, 1, 3, 2, 0, 0, 1, 1, 1, 2, 2, 2};
  int unsigned ph_num[15] = '{40, 40, 45, 45, 40, 40, 40, 40, 40, 6, 40, 45, 30, 45, 5};

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    err_cnt = 0;
    no_idle = 1'b0;
    cur_kb = 4; cur_blk = 4; cur_map = ctsr_pkg::MapDirect; cur_pol = ctsr_pkg::PolFifo;
    foreach (valid_mem[i]) begin
      valid_mem[i] = 1'b0;
      tag_mem[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset geometry, field extremes, hits, conflicts
    pending_addr.push_back(32'h0000_0000);
    pending_addr.push_back(32'h0000_0000);
    pending_addr.push_back(32'hFFFF_FFFF);
    pending_addr.push_back(32'hFFFF_FFFF);
    pending_addr.push_back(32'h8000_0000);
    pending_addr.push_back(32'h0000_000F);
    pending_addr.push_back(32'h0000_4000);
    pending_addr.push_back(32'h8000_4000);
    pending_addr.push_back(32'h0000_0000);
    pending_addr.push_back(32'h7FFF_FFF0);
    wait_drained();

    for (int p = 0; p < 15; p++) begin
      for (int k = 0; k < 6; k++) begin
        hi_pool[k] = $urandom();
        lo_pool[k] = $urandom();
      end
      write_reg(ctsr_pkg::CfgKbLog2, ph_kb[p]);
      write_reg(ctsr_pkg::CfgBlockLog2, ph_blk[p]);
      write_reg(ctsr_pkg::CfgMapping, ph_map[p]);
      write_reg(ctsr_pkg::CfgPolicy, ph_pol[p]);
      no_idle = (p == 3);
      for (int n = 0; n < ph_num[p]; n++) pending_addr.push_back(rand_addr());
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
